### hw/rtl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Types and constants shared by the IR pulse-distance receiver and its
// channel interfaces.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int RX_BYTE_W   = 8;
    localparam int BYTE_POS_W  = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int THRESH_W    = 16;
    localparam int TIMEOUT_W   = 16;
    localparam int MSG_BYTES_W = 5;
    localparam int BIT_CNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_BYTES = 2'd2;

    localparam logic [THRESH_W-1:0]    RST_BIT_THRESHOLD = 16'd1000;
    localparam logic [TIMEOUT_W-1:0]   RST_PHASE_TIMEOUT = 16'd12000;
    localparam logic [MSG_BYTES_W-1:0] RST_MESSAGE_BYTES = 5'd4;

    // Two preamble high/low pairs, then alternating bit high and bit low.
    typedef enum logic [5:0] {
        PH_PRE_HIGH_A = 6'b000001,
        PH_PRE_LOW_A  = 6'b000010,
        PH_PRE_HIGH_B = 6'b000100,
        PH_PRE_LOW_B  = 6'b001000,
        PH_BIT_HIGH   = 6'b010000,
        PH_BIT_LOW    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [RX_BYTE_W-1:0]  rx_byte;
        logic [BYTE_POS_W-1:0] byte_position;
        logic                  last_of_message;
        logic                  timed_out;
    } t_result;

endpackage

### hw/rtl/irpd_ifs.sv
// ----------------------------------------------------------------------------
// irpd channel interfaces
// Valid/ready channels for line samples in and received bytes out.
// ----------------------------------------------------------------------------
interface irpd_sample_if;
    logic valid;
    logic ready;
    logic rx_level;

    modport source (output valid, output rx_level, input ready);
    modport sink   (input valid, input rx_level, output ready);
endinterface

interface irpd_result_if;
    logic                             valid;
    logic                             ready;
    logic [irpd_pkg::RX_BYTE_W-1:0]   rx_byte;
    logic [irpd_pkg::BYTE_POS_W-1:0]  byte_position;
    logic                             last_of_message;
    logic                             timed_out;

    modport source (output valid, output rx_byte, output byte_position,
                    output last_of_message, output timed_out, input ready);
    modport sink   (input valid, input rx_byte, input byte_position,
                    input last_of_message, input timed_out, output ready);
endinterface

### hw/rtl/ir_pulse_distance_receiver.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_receiver
// Decodes a pulse-distance IR line into bytes, one line sample per item.
// ----------------------------------------------------------------------------
// Usage:
// i_rx carries one demodulated line sample per microsecond tick. o_res
// carries at most one result per sample: a completed byte with its position
// and a last-of-message flag, or a timeout marker telling the consumer to drop
// the partial message. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data by the user only while the block is idle; the block does not enforce it.
// Throughput is one sample per cycle while i_rx.ready is high. The sample that
// completes a result registers it on o_res, or in the skid buffer if o_res is
// still held; the phase, timer and shift state update in the cycle a sample is taken.
// The result register is backed by a one-entry skid buffer, so samples keep
// being taken while a single result waits. i_rx.ready is low only while the
// skid buffer holds a result, which needs a second result to arrive while the
// first still waits; ready returns the cycle after the consumer takes one.
// Synchronous reset restores the register defaults, empties the result path
// and arms the decoder at the first preamble high phase.
// ----------------------------------------------------------------------------
module ir_pulse_distance_receiver #(
    parameter int TIMER_WIDTH       = 16,
    parameter int MAX_MESSAGE_BYTES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    irpd_sample_if.sink                         i_rx,
    irpd_result_if.source                       o_res,
    input  logic                                i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int BC_W   = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int LEN_RW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int LEN_W  = (LEN_RW > irpd_pkg::MSG_BYTES_W) ? LEN_RW
                                                             : irpd_pkg::MSG_BYTES_W;
    localparam int CMP_W  = (TIMER_WIDTH > irpd_pkg::TIMEOUT_W) ? TIMER_WIDTH
                                                                : irpd_pkg::TIMEOUT_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
    localparam logic [LEN_W-1:0]       MAX_LEN   = LEN_W'(MAX_MESSAGE_BYTES);

    // Configuration registers.
    logic [irpd_pkg::THRESH_W-1:0]    r_bit_threshold;
    logic [irpd_pkg::TIMEOUT_W-1:0]   r_phase_timeout;
    logic [irpd_pkg::MSG_BYTES_W-1:0] r_message_bytes;

    // Decoder state.
    irpd_pkg::t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0]           r_elapsed, n_elapsed;
    logic [irpd_pkg::BIT_CNT_W-1:0]   r_bit_count, n_bit_count;
    logic [BC_W-1:0]                  r_byte_count, n_byte_count;
    logic [irpd_pkg::RX_BYTE_W-1:0]   r_shift, n_shift;

    // Result path.
    logic                             r_out_valid;
    irpd_pkg::t_result                r_out;
    logic                             r_skid_valid;
    irpd_pkg::t_result                r_skid;

    logic                             take;
    logic                             out_fire;
    logic                             waits_high;
    logic                             res_valid;
    irpd_pkg::t_result                res;
    logic [LEN_W-1:0]                 eff_len;
    logic [LEN_W-1:0]                 pos_plus;
    logic                             last;

    assign i_rx.ready = !r_skid_valid;
    assign take       = i_rx.valid && !r_skid_valid;
    assign out_fire   = r_out_valid && o_res.ready;

    always_comb begin
        if (r_message_bytes == '0) begin
            eff_len = LEN_W'(1);
        end else if (LEN_W'(r_message_bytes) > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = LEN_W'(r_message_bytes);
        end
    end

    assign pos_plus   = LEN_W'(r_byte_count) + LEN_W'(1);
    assign last       = pos_plus >= eff_len;
    assign waits_high = (r_phase == irpd_pkg::PH_PRE_HIGH_A) ||
                        (r_phase == irpd_pkg::PH_PRE_HIGH_B) ||
                        (r_phase == irpd_pkg::PH_BIT_HIGH);

    always_comb begin
        n_phase      = r_phase;
        n_elapsed    = r_elapsed;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_shift      = r_shift;
        res_valid    = 1'b0;
        res          = '0;

        if (i_rx.rx_level == waits_high) begin
            if (r_elapsed != TIMER_MAX) begin
                n_elapsed = r_elapsed + TIMER_WIDTH'(1);
            end
        end else begin
            // The opposite level ends this phase and is the next phase's first tick.
            n_elapsed = TIMER_WIDTH'(1);
            case (r_phase)
                irpd_pkg::PH_PRE_HIGH_A: begin
                    n_phase = irpd_pkg::PH_PRE_LOW_A;
                end
                irpd_pkg::PH_PRE_LOW_A: begin
                    n_phase = irpd_pkg::PH_PRE_HIGH_B;
                end
                irpd_pkg::PH_PRE_HIGH_B: begin
                    n_phase = irpd_pkg::PH_PRE_LOW_B;
                end
                irpd_pkg::PH_PRE_LOW_B: begin
                    n_phase = irpd_pkg::PH_BIT_HIGH;
                end
                irpd_pkg::PH_BIT_HIGH: begin
                    n_phase     = irpd_pkg::PH_BIT_LOW;
                    n_shift     = {r_shift[irpd_pkg::RX_BYTE_W-2:0],
                                   (CMP_W'(r_elapsed) > CMP_W'(r_bit_threshold))};
                    n_bit_count = r_bit_count + irpd_pkg::BIT_CNT_W'(1);
                end
                irpd_pkg::PH_BIT_LOW: begin
                    n_phase = irpd_pkg::PH_BIT_HIGH;
                    if (r_bit_count == '0) begin
                        res_valid           = 1'b1;
                        res.rx_byte         = r_shift;
                        res.byte_position   = irpd_pkg::BYTE_POS_W'(r_byte_count);
                        res.last_of_message = last;
                        n_shift             = '0;
                        if (last) begin
                            n_phase      = irpd_pkg::PH_PRE_HIGH_A;
                            n_byte_count = '0;
                        end else begin
                            n_byte_count = BC_W'(pos_plus);
                        end
                    end
                end
                default: begin
                    n_phase = irpd_pkg::PH_PRE_HIGH_A;
                end
            endcase
        end

        // A phase that outlasts the timeout overrides any byte and rearms.
        if (CMP_W'(n_elapsed) > CMP_W'(r_phase_timeout)) begin
            res_valid     = 1'b1;
            res           = '0;
            res.timed_out = 1'b1;
            n_phase       = irpd_pkg::PH_PRE_HIGH_A;
            n_elapsed     = '0;
            n_bit_count   = '0;
            n_byte_count  = '0;
            n_shift       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_threshold <= irpd_pkg::RST_BIT_THRESHOLD;
            r_phase_timeout <= irpd_pkg::RST_PHASE_TIMEOUT;
            r_message_bytes <= irpd_pkg::RST_MESSAGE_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                irpd_pkg::CFG_BIT_THRESHOLD: begin
                    r_bit_threshold <= i_cfg_data[irpd_pkg::THRESH_W-1:0];
                end
                irpd_pkg::CFG_PHASE_TIMEOUT: begin
                    r_phase_timeout <= i_cfg_data[irpd_pkg::TIMEOUT_W-1:0];
                end
                irpd_pkg::CFG_MESSAGE_BYTES: begin
                    r_message_bytes <= i_cfg_data[irpd_pkg::MSG_BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= irpd_pkg::PH_PRE_HIGH_A;
            r_elapsed    <= '0;
            r_bit_count  <= '0;
            r_byte_count <= '0;
            r_shift      <= '0;
        end else if (take) begin
            r_phase      <= n_phase;
            r_elapsed    <= n_elapsed;
            r_bit_count  <= n_bit_count;
            r_byte_count <= n_byte_count;
            r_shift      <= n_shift;
        end
    end

    // Output register with a one-entry skid buffer behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (take && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (take && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.rx_byte         = r_out.rx_byte;
    assign o_res.byte_position   = r_out.byte_position;
    assign o_res.last_of_message = r_out.last_of_message;
    assign o_res.timed_out       = r_out.timed_out;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IR pulse-distance receiver. Line samples are
// driven one item at a time; a behavioral decoder kept inside the bench
// predicts every received byte and every timeout marker, and a checker
// compares each result item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [irpd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int MAX_MSG_BYTES = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef logic [irpd_pkg::RX_BYTE_W-1:0]  t_byte;
    typedef logic [irpd_pkg::CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [irpd_pkg::TIMEOUT_W-1:0]  t_ticks;
    typedef t_byte t_byte_q[$];

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [irpd_pkg::CFG_DATA_W-1:0] cfg_data;

    irpd_sample_if smp_if();
    irpd_result_if res_if();

    ir_pulse_distance_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Decoder state and register shadows.
    irpd_pkg::t_phase                 dec_phase;
    t_ticks                           dec_ticks;
    logic [irpd_pkg::BIT_CNT_W-1:0]   dec_bits;
    int                               dec_byte_idx;
    t_byte                            dec_shift;
    logic [irpd_pkg::THRESH_W-1:0]    cfg_threshold;
    logic [irpd_pkg::TIMEOUT_W-1:0]   cfg_timeout;
    logic [irpd_pkg::MSG_BYTES_W-1:0] cfg_msg_bytes;

    irpd_pkg::t_result predicted_bytes[$];
    irpd_pkg::t_result want_byte;

    int send_idle_pct  = 30;
    int recv_idle_pct  = 66;
    int samples_sent   = 0;
    int mismatch_count = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int msg_length();
        int n;
        n = int'(cfg_msg_bytes);
        if (n < 1) n = 1;
        if (n > MAX_MSG_BYTES) n = MAX_MSG_BYTES;
        return n;
    endfunction

    function automatic int pick_len(input int lo, input int hi);
        if (hi <= lo) return lo;
        return int'($urandom_range(hi, lo));
    endfunction

    function automatic void rearm_decoder();
        dec_phase    = irpd_pkg::PH_PRE_HIGH_A;
        dec_ticks    = '0;
        dec_bits     = '0;
        dec_byte_idx = 0;
        dec_shift    = '0;
    endfunction

    function automatic void decode_sample(input logic level);
        logic              waits_high;
        logic              last;
        irpd_pkg::t_phase  nxt;
        irpd_pkg::t_result r;
        bit                emit;
        emit = 1'b0;
        r    = '0;
        waits_high = (dec_phase == irpd_pkg::PH_PRE_HIGH_A) ||
                     (dec_phase == irpd_pkg::PH_PRE_HIGH_B) ||
                     (dec_phase == irpd_pkg::PH_BIT_HIGH);
        if (level == waits_high) begin
            if (dec_ticks != '1) dec_ticks = dec_ticks + 1'b1;
        end else begin
            // The sample that ends a phase is the first tick of the next one.
            case (dec_phase)
                irpd_pkg::PH_PRE_HIGH_A: nxt = irpd_pkg::PH_PRE_LOW_A;
                irpd_pkg::PH_PRE_LOW_A:  nxt = irpd_pkg::PH_PRE_HIGH_B;
                irpd_pkg::PH_PRE_HIGH_B: nxt = irpd_pkg::PH_PRE_LOW_B;
                irpd_pkg::PH_PRE_LOW_B:  nxt = irpd_pkg::PH_BIT_HIGH;
                irpd_pkg::PH_BIT_HIGH: begin
                    nxt       = irpd_pkg::PH_BIT_LOW;
                    dec_shift = {dec_shift[irpd_pkg::RX_BYTE_W-2:0],
                                 (dec_ticks > cfg_threshold)};
                    dec_bits  = dec_bits + 1'b1;
                end
                irpd_pkg::PH_BIT_LOW: begin
                    nxt = irpd_pkg::PH_BIT_HIGH;
                    if (dec_bits == '0) begin
                        last              = (dec_byte_idx + 1) >= msg_length();
                        r.rx_byte         = dec_shift;
                        r.byte_position   = dec_byte_idx[irpd_pkg::BYTE_POS_W-1:0];
                        r.last_of_message = last;
                        emit              = 1'b1;
                        dec_shift         = '0;
                        if (last) begin
                            rearm_decoder();
                            nxt = irpd_pkg::PH_PRE_HIGH_A;
                        end else begin
                            dec_byte_idx++;
                        end
                    end
                end
                default: nxt = irpd_pkg::PH_PRE_HIGH_A;
            endcase
            dec_phase = nxt;
            dec_ticks = t_ticks'(1);
        end
        // A timeout replaces any byte completed by the same sample.
        if (dec_ticks > cfg_timeout) begin
            r           = '0;
            r.timed_out = 1'b1;
            emit        = 1'b1;
            rearm_decoder();
        end
        if (emit) predicted_bytes.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_sample(input logic level);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            smp_if.valid <= 1'b0;
        end
        @(negedge clk);
        smp_if.valid    <= 1'b1;
        smp_if.rx_level <= level;
        @(posedge clk);
        while (smp_if.ready !== 1'b1) @(posedge clk);
        decode_sample(level);
        samples_sent++;
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) send_sample(level);
    endtask

    // Tight timing sits right on the threshold: a zero is exactly threshold
    // ticks long and a one is one tick longer; every other phase is one tick.
    task automatic send_bit(input logic value, input bit tight);
        int high_len;
        if (value) high_len = tight ? int'(cfg_threshold) + 1
                                    : pick_len(int'(cfg_threshold) + 1, int'(cfg_timeout));
        else       high_len = tight ? int'(cfg_threshold) : pick_len(1, int'(cfg_threshold));
        if (high_len < 1) high_len = 1;
        send_run(1'b1, high_len);
        send_run(1'b0, tight ? 1 : pick_len(1, int'(cfg_timeout)));
    endtask

    task automatic send_byte(input t_byte value, input bit tight);
        for (int i = irpd_pkg::RX_BYTE_W - 1; i >= 0; i--) send_bit(value[i], tight);
    endtask

    task automatic send_preamble(input bit tight);
        repeat (2) begin
            send_run(1'b1, tight ? 1 : pick_len(1, int'(cfg_timeout)));
            send_run(1'b0, tight ? 1 : pick_len(1, int'(cfg_timeout)));
        end
    endtask

    // The trailing high sample ends the last low phase and releases the byte.
    task automatic send_message(input t_byte_q msg, input bit tight);
        send_preamble(tight);
        foreach (msg[i]) send_byte(msg[i], tight);
        send_run(1'b1, 1);
    endtask

    task automatic idle_until_rearmed();
        while (!(dec_phase == irpd_pkg::PH_PRE_HIGH_A && dec_ticks == '0))
            send_sample(1'b0);
    endtask

    task automatic drain();
        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (predicted_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                             input t_cfg_data value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            irpd_pkg::CFG_BIT_THRESHOLD: cfg_threshold = value[irpd_pkg::THRESH_W-1:0];
            irpd_pkg::CFG_PHASE_TIMEOUT: cfg_timeout   = value[irpd_pkg::TIMEOUT_W-1:0];
            irpd_pkg::CFG_MESSAGE_BYTES: cfg_msg_bytes = value[irpd_pkg::MSG_BYTES_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // Single-tick high phases read as zero under the default threshold,
        // and the default length closes the message after its last byte.
        send_preamble(1'b1);
        repeat (int'(irpd_pkg::RST_MESSAGE_BYTES) * irpd_pkg::RX_BYTE_W) begin
            send_run(1'b1, 1);
            send_run(1'b0, 1);
        end
        send_run(1'b1, 1);
    endtask

    task automatic test_threshold_extremes();
        t_byte_q msg;
        drain();
        write_reg(irpd_pkg::CFG_BIT_THRESHOLD, 16'd0);
        write_reg(irpd_pkg::CFG_PHASE_TIMEOUT, 16'd3);
        write_reg(irpd_pkg::CFG_MESSAGE_BYTES, 16'd1);
        idle_until_rearmed();
        // With a zero threshold even the shortest high phase reads as one.
        msg = '{8'h00};
        send_message(msg, 1'b1);
        drain();
        write_reg(irpd_pkg::CFG_BIT_THRESHOLD, 16'd1);
        write_reg(irpd_pkg::CFG_PHASE_TIMEOUT, 16'd2);
        idle_until_rearmed();
        msg = '{8'h96};
        send_message(msg, 1'b1);
    endtask

    task automatic test_zero_timeout();
        drain();
        write_reg(irpd_pkg::CFG_PHASE_TIMEOUT, 16'd0);
        for (int i = 0; i < 6; i++) send_sample(i[1] ^ i[0]);
        drain();
        write_reg(irpd_pkg::CFG_PHASE_TIMEOUT, 16'd2);
    endtask

    task automatic test_message_lengths();
        t_cfg_data lengths[4];
        t_byte_q   msg;
        lengths = '{16'd0, 16'd1, 16'd17, 16'hFFE3};
        foreach (lengths[k]) begin
            drain();
            write_reg(irpd_pkg::CFG_MESSAGE_BYTES, lengths[k]);
            idle_until_rearmed();
            msg.delete();
            repeat (msg_length()) msg.push_back(t_byte'($urandom_range(255)));
            send_message(msg, 1'b1);
        end
    endtask

    task automatic test_length_change();
        drain();
        write_reg(irpd_pkg::CFG_BIT_THRESHOLD, 16'd1);
        write_reg(irpd_pkg::CFG_PHASE_TIMEOUT, 16'd4);
        write_reg(irpd_pkg::CFG_MESSAGE_BYTES, 16'd8);
        idle_until_rearmed();
        send_preamble(1'b1);
        repeat (3) send_byte(t_byte'($urandom_range(255)), 1'b1);
        send_run(1'b1, 1);
        // Shrinking the length below the bytes already taken ends the message
        // on the very next byte.
        drain();
        write_reg(irpd_pkg::CFG_MESSAGE_BYTES, 16'd2);
        write_reg(CFG_SPARE, t_cfg_data'($urandom_range(16'hFFFF)));
        send_byte(t_byte'($urandom_range(255)), 1'b1);
        send_run(1'b1, 1);
    endtask

    task automatic test_random_traffic(input int target);
        int      first_sample;
        int      eff;
        int      choice;
        int      thr;
        t_byte_q msg;
        drain();
        thr    = int'($urandom_range(4, 1));
        choice = int'($urandom_range(99));
        write_reg(irpd_pkg::CFG_BIT_THRESHOLD, t_cfg_data'(thr));
        write_reg(irpd_pkg::CFG_PHASE_TIMEOUT, t_cfg_data'($urandom_range(14, thr + 2)));
        if (choice < 70)
            write_reg(irpd_pkg::CFG_MESSAGE_BYTES, t_cfg_data'($urandom_range(4, 1)));
        else if (choice < 85)
            write_reg(irpd_pkg::CFG_MESSAGE_BYTES, t_cfg_data'($urandom_range(16, 5)));
        else if (choice < 92)
            write_reg(irpd_pkg::CFG_MESSAGE_BYTES, 16'd0);
        else
            write_reg(irpd_pkg::CFG_MESSAGE_BYTES, t_cfg_data'($urandom_range(31, 17)));
        idle_until_rearmed();
        first_sample = samples_sent;
        while (samples_sent - first_sample < target) begin
            choice = int'($urandom_range(99));
            eff    = msg_length();
            if (choice < 75) begin
                msg.delete();
                repeat (eff) msg.push_back(t_byte'($urandom_range(255)));
                send_message(msg, $urandom_range(4) == 0);
            end else if (choice < 87) begin
                // Message cut short, then left to time out.
                send_preamble(1'b0);
                repeat ($urandom_range(eff - 1))
                    send_byte(t_byte'($urandom_range(255)), 1'b0);
                repeat ($urandom_range(7)) send_bit(1'($urandom_range(1)), 1'b0);
                if ($urandom_range(1)) send_run(1'b1, int'(cfg_timeout) + 1);
                idle_until_rearmed();
            end else if (choice < 95) begin
                repeat ($urandom_range(6, 1))
                    send_run(1'($urandom_range(1)), pick_len(1, int'(cfg_timeout) + 2));
            end else begin
                send_run(1'b0, pick_len(1, 3 * int'(cfg_timeout)));
                idle_until_rearmed();
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (predicted_bytes.size() == 0) begin
                report_mismatch("unexpected result, rx_byte", res_if.rx_byte, 8'h00);
            end else begin
                want_byte = predicted_bytes.pop_front();
                if (res_if.rx_byte !== want_byte.rx_byte)
                    report_mismatch("rx_byte", res_if.rx_byte, want_byte.rx_byte);
                if (res_if.byte_position !== want_byte.byte_position)
                    report_mismatch("byte_position", 8'(res_if.byte_position),
                                    8'(want_byte.byte_position));
                if (res_if.last_of_message !== want_byte.last_of_message)
                    report_mismatch("last_of_message", 8'(res_if.last_of_message),
                                    8'(want_byte.last_of_message));
                if (res_if.timed_out !== want_byte.timed_out)
                    report_mismatch("timed_out", 8'(res_if.timed_out),
                                    8'(want_byte.timed_out));
            end
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((smp_if.valid === 1'b1 && smp_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = irpd_pkg::CFG_BIT_THRESHOLD;
        cfg_data        = '0;
        smp_if.valid    = 1'b0;
        smp_if.rx_level = 1'b0;
        cfg_threshold   = irpd_pkg::RST_BIT_THRESHOLD;
        cfg_timeout     = irpd_pkg::RST_PHASE_TIMEOUT;
        cfg_msg_bytes   = irpd_pkg::RST_MESSAGE_BYTES;
        rearm_decoder();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_threshold_extremes();
        test_zero_timeout();
        test_message_lengths();
        test_length_change();

        test_random_traffic(150);
        send_idle_pct = 66;
        recv_idle_pct = 30;
        test_random_traffic(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(150);

        drain();
        if (mismatch_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
